@@ src/rrsf_pkg.sv @@
// Shared types, constants and sizes for the remote-control sentence framer.
// Depends on nothing; every other file in src uses it by scoped names.
package rrsf_pkg;

    // Largest number of ident characters the protocol allows in one sentence.
    localparam int IDENT_MAX_CHARS = 4;
    // Number of ident character fields in a request.
    localparam int IDENT_FIELDS = 4;
    // Ident characters actually sent at most.
    localparam int IDENT_LIMIT =
        (IDENT_MAX_CHARS < IDENT_FIELDS) ? IDENT_MAX_CHARS : IDENT_FIELDS;
    // Frequency list payload bytes.
    localparam int FREQ_FIELDS = 3;
    // Payload slots: the larger of the two message kinds.
    localparam int PAY_MAX = (IDENT_LIMIT > FREQ_FIELDS) ? IDENT_LIMIT : FREQ_FIELDS;
    localparam int PAY_IDX_W = (PAY_MAX > 1) ? $clog2(PAY_MAX) : 1;
    localparam int PAY_LEN_W = $clog2(PAY_MAX + 1);

    // Sentence layout: header, '0', message id, list digit, payload, checksum, CR LF.
    localparam int HEADER_LEN = 6;
    localparam int PREFIX_LEN = HEADER_LEN + 3;
    localparam int TAIL_LEN   = 4;
    localparam int FRAME_MAX  = PREFIX_LEN + PAY_MAX + TAIL_LEN;
    localparam int FRAME_LEN_W = $clog2(FRAME_MAX + 1);

    // Header text, first byte in the lowest slot.
    localparam logic [HEADER_LEN-1:0][7:0] HEADER_TEXT =
        {8'h43, 8'h52, 8'h52, 8'h4D, 8'h50, 8'h24};

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ID_IDENT   = 8'h34;
    localparam logic [7:0] ID_FREQ    = 8'h35;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] NIBBLE_HI  = 8'hF0;
    localparam logic [7:0] NIBBLE_LO  = 8'h0F;

    // Request kinds.
    localparam logic REQ_IDENT = 1'b0;
    localparam logic REQ_FREQ  = 1'b1;

    // One request beat.
    typedef struct packed {
        logic       req_type;
        logic [3:0] list_index;
        logic [7:0] ident_char_0;
        logic [7:0] ident_char_1;
        logic [7:0] ident_char_2;
        logic [7:0] ident_char_3;
        logic [7:0] freq_kind;
        logic [7:0] mhz_code;
        logic [7:0] khz_code;
    } t_req;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_res;

    // A whole sentence laid out byte by byte, with its length.
    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [FRAME_LEN_W-1:0]    len;
    } t_frame;

endpackage

@@ src/rrsf_frame_build.sv @@
// Sentence assembly: lays out one request as a complete sentence and its length.
// Depends on rrsf_pkg.
module rrsf_frame_build (
    input  rrsf_pkg::t_req   i_req,
    output rrsf_pkg::t_frame o_frame
);

    logic [rrsf_pkg::PAY_MAX-1:0][7:0] pay;
    logic [rrsf_pkg::PAY_LEN_W-1:0]    pay_len;
    logic [rrsf_pkg::TAIL_LEN-1:0][7:0] tail;
    logic [7:0]                         msg_id;
    logic [7:0]                         digit;
    logic [7:0]                         sum;

    // Gather the payload bytes, packed to the front of the slot array.
    always_comb begin
        logic [rrsf_pkg::IDENT_FIELDS-1:0][7:0] id_ch;
        logic [rrsf_pkg::FREQ_FIELDS-1:0][7:0]  fq;
        logic                                    stop;
        id_ch   = {i_req.ident_char_3, i_req.ident_char_2,
                   i_req.ident_char_1, i_req.ident_char_0};
        fq      = {i_req.khz_code, i_req.mhz_code, i_req.freq_kind};
        stop    = 1'b0;
        pay     = '0;
        pay_len = '0;
        if (i_req.req_type == rrsf_pkg::REQ_IDENT) begin
            // Ident characters run up to the first zero byte.
            for (int i = 0; i < rrsf_pkg::IDENT_LIMIT; i++) begin
                if (!stop && id_ch[i] != 8'h00) begin
                    pay[pay_len[rrsf_pkg::PAY_IDX_W-1:0]] = id_ch[i];
                    pay_len = pay_len + 1'b1;
                end else begin
                    stop = 1'b1;
                end
            end
        end else begin
            // Frequency bytes that are zero are left out.
            for (int i = 0; i < rrsf_pkg::FREQ_FIELDS; i++) begin
                if (fq[i] != 8'h00) begin
                    pay[pay_len[rrsf_pkg::PAY_IDX_W-1:0]] = fq[i];
                    pay_len = pay_len + 1'b1;
                end
            end
        end
    end

    // Message id, list digit and the 8-bit additive checksum.
    always_comb begin
        msg_id = (i_req.req_type == rrsf_pkg::REQ_IDENT) ? rrsf_pkg::ID_IDENT
                                                          : rrsf_pkg::ID_FREQ;
        digit  = rrsf_pkg::ASCII_ZERO + {4'h0, i_req.list_index};
        sum    = rrsf_pkg::ASCII_ZERO + msg_id + digit;
        for (int i = 0; i < rrsf_pkg::PAY_MAX; i++) begin
            sum = sum + pay[i];
        end
        tail[0] = ((sum & rrsf_pkg::NIBBLE_HI) >> 4) + rrsf_pkg::ASCII_ZERO;
        tail[1] = (sum & rrsf_pkg::NIBBLE_LO) + rrsf_pkg::ASCII_ZERO;
        tail[2] = rrsf_pkg::ASCII_CR;
        tail[3] = rrsf_pkg::ASCII_LF;
    end

    // Place every byte in its slot; the tail follows straight after the payload.
    always_comb begin
        logic [rrsf_pkg::FRAME_LEN_W-1:0] k;
        logic [rrsf_pkg::FRAME_LEN_W-1:0] t;
        k = '0;
        t = '0;
        for (int i = 0; i < rrsf_pkg::FRAME_MAX; i++) begin
            if (i < rrsf_pkg::HEADER_LEN) begin
                o_frame.bytes[i] = rrsf_pkg::HEADER_TEXT[i];
            end else if (i == rrsf_pkg::HEADER_LEN) begin
                o_frame.bytes[i] = rrsf_pkg::ASCII_ZERO;
            end else if (i == rrsf_pkg::HEADER_LEN + 1) begin
                o_frame.bytes[i] = msg_id;
            end else if (i == rrsf_pkg::HEADER_LEN + 2) begin
                o_frame.bytes[i] = digit;
            end else begin
                k = rrsf_pkg::FRAME_LEN_W'(i - rrsf_pkg::PREFIX_LEN);
                t = k - rrsf_pkg::FRAME_LEN_W'(pay_len);
                if (k < rrsf_pkg::FRAME_LEN_W'(pay_len)) begin
                    o_frame.bytes[i] = pay[k[rrsf_pkg::PAY_IDX_W-1:0]];
                end else if (t < rrsf_pkg::FRAME_LEN_W'(rrsf_pkg::TAIL_LEN)) begin
                    o_frame.bytes[i] = tail[t[1:0]];
                end else begin
                    o_frame.bytes[i] = 8'h00;
                end
            end
        end
        o_frame.len = rrsf_pkg::FRAME_LEN_W'(rrsf_pkg::PREFIX_LEN + rrsf_pkg::TAIL_LEN)
                    + rrsf_pkg::FRAME_LEN_W'(pay_len);
    end

endmodule

@@ src/rrsf_serialiser.sv @@
// Sentence register and byte shifter: holds one laid-out sentence and sends a byte per cycle.
// Depends on rrsf_pkg.
module rrsf_serialiser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rrsf_pkg::t_frame i_frame,
    output logic             o_busy,
    output logic             o_strobe,
    output rrsf_pkg::t_res   o_res
);

    logic [rrsf_pkg::FRAME_MAX-1:0][7:0] r_frame, n_frame;
    logic [rrsf_pkg::FRAME_LEN_W-1:0]    r_remain, n_remain;
    logic                                r_strobe, n_strobe;
    rrsf_pkg::t_res                      r_res, n_res;
    logic                                accept;

    // A new request may load while the final byte of the previous one leaves.
    assign o_busy = (r_remain > rrsf_pkg::FRAME_LEN_W'(1));
    assign accept = i_start && !o_busy;

    // Load a new sentence, or shift the current one down by a byte.
    always_comb begin
        n_frame  = r_frame;
        n_remain = r_remain;
        if (accept) begin
            n_frame  = i_frame.bytes;
            n_remain = i_frame.len;
        end else if (r_remain != '0) begin
            n_frame  = {8'h00, r_frame[rrsf_pkg::FRAME_MAX-1:1]};
            n_remain = r_remain - 1'b1;
        end
    end

    // The head byte goes to the result register whenever a sentence is in flight.
    always_comb begin
        n_strobe        = (r_remain != '0);
        n_res.out_byte  = r_frame[0];
        n_res.last_byte = (r_remain == rrsf_pkg::FRAME_LEN_W'(1));
    end

    // Control state is reset; the byte store and result payload are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_remain <= n_remain;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_res   <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // A sentence leaves without gaps until its final byte.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last_byte) |=> o_strobe)
        else $error("gap inside a sentence");

    // An accepted request always occupies the block for more than one beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("block not busy after accepting a request");

    // The final beat of a sentence is always the line feed.
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last_byte) |-> (o_res.out_byte == rrsf_pkg::ASCII_LF))
        else $error("final beat is not a line feed");

    // The block was open to a new request in the cycle before the final beat.
    a_ready_before_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last_byte) |-> $past(!o_busy))
        else $error("busy was still high before the final beat");

endmodule

@@ src/radio_remote_sentence_framer.sv @@
// Top level of the remote-control sentence framer.
// Depends on rrsf_pkg, rrsf_frame_build and rrsf_serialiser.
//
// Usage:
//   A request is presented on i_req with start high; it is taken at a rising
//   edge where start is high and busy is low. The request is laid out as a
//   full ASCII sentence (header, '0', message id, list digit, payload, two
//   checksum characters, CR LF) and latched in the sentence register.
//   Result beats appear on o_res, one byte per cycle, each marked by o_strobe
//   for exactly one cycle; last_byte is set on the closing line feed.
//   The first byte of a taken request passes through the sentence register
//   and then the result register before it is on the outputs. A sentence
//   of N bytes (13 to 17) gives N consecutive beats, as the byte shifter
//   sends one byte per cycle.
//   busy falls in the cycle before the final beat, so a request taken then
//   starts its first byte straight after the line feed of the one before.
//   Reset (synchronous, active low) abandons any sentence in flight and
//   leaves the block idle with o_strobe low.
//   The receiver has no way to hold beats off; every strobed beat must be
//   taken in its cycle.
module radio_remote_sentence_framer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  rrsf_pkg::t_req i_req,
    output logic           busy,
    output logic           o_strobe,
    output rrsf_pkg::t_res o_res
);

    rrsf_pkg::t_frame frame;

    // Combinational sentence layout of the incoming request.
    rrsf_frame_build u_build (
        .i_req   (i_req),
        .o_frame (frame)
    );

    // Sentence register, byte shifter and result register.
    rrsf_serialiser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_frame  (frame),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

@@ tb/tb_radio_remote_sentence_framer.sv @@
// Testbench for the remote-control sentence framer: directed and random requests,
// with each sentence predicted byte by byte and checked beat by beat on the outputs.
// Depends on rrsf_pkg and radio_remote_sentence_framer.
module tb_radio_remote_sentence_framer;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    rrsf_pkg::t_req i_req;
    logic busy;
    logic o_strobe;
    rrsf_pkg::t_res o_res;

    // Sentence bytes still owed by the block, oldest first.
    rrsf_pkg::t_res pending_bytes[$];

    int requests_sent = 0;
    int ident_sent    = 0;
    int freq_sent     = 0;
    int bytes_checked = 0;
    int faults        = 0;
    int cycle_count   = 0;

    radio_remote_sentence_framer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // Free-running clock, 20 units per period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Count a failure; only the first few are described in full.
    task automatic report_fault(input string what);
        faults++;
        if (faults <= REPORT_MAX) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    function automatic rrsf_pkg::t_res sentence_beat(input logic [7:0] b, input logic last);
        rrsf_pkg::t_res beat;
        beat.out_byte  = b;
        beat.last_byte = last;
        return beat;
    endfunction

    // Lay out the full sentence for one request and queue its bytes.
    task automatic frame_sentence(input rrsf_pkg::t_req r);
        logic [7:0] body[$];
        logic [7:0] ident[rrsf_pkg::IDENT_FIELDS];
        logic [7:0] freq[3];
        logic [7:0] sum;
        int         limit;
        sum = 8'h00;
        body.push_back(rrsf_pkg::ASCII_ZERO);
        body.push_back((r.req_type == rrsf_pkg::REQ_FREQ) ? rrsf_pkg::ID_FREQ
                                                          : rrsf_pkg::ID_IDENT);
        body.push_back(rrsf_pkg::ASCII_ZERO + 8'(r.list_index));
        if (r.req_type == rrsf_pkg::REQ_IDENT) begin
            // Ident characters run up to the first zero byte.
            ident = '{r.ident_char_0, r.ident_char_1, r.ident_char_2, r.ident_char_3};
            limit = (rrsf_pkg::IDENT_MAX_CHARS < rrsf_pkg::IDENT_FIELDS)
                  ? rrsf_pkg::IDENT_MAX_CHARS : rrsf_pkg::IDENT_FIELDS;
            for (int i = 0; i < limit; i++) begin
                if (ident[i] == 8'h00) begin
                    break;
                end
                body.push_back(ident[i]);
            end
        end else begin
            // Frequency bytes that are zero are simply left out.
            freq = '{r.freq_kind, r.mhz_code, r.khz_code};
            foreach (freq[i]) begin
                if (freq[i] != 8'h00) begin
                    body.push_back(freq[i]);
                end
            end
        end
        foreach (body[i]) begin
            sum += body[i];
        end
        for (int i = 0; i < rrsf_pkg::HEADER_LEN; i++) begin
            pending_bytes.push_back(sentence_beat(rrsf_pkg::HEADER_TEXT[i], 1'b0));
        end
        foreach (body[i]) begin
            pending_bytes.push_back(sentence_beat(body[i], 1'b0));
        end
        // Checksum nibbles are offset from '0', so they are not hex digits.
        pending_bytes.push_back(sentence_beat(
            ((sum & rrsf_pkg::NIBBLE_HI) >> 4) + rrsf_pkg::ASCII_ZERO, 1'b0));
        pending_bytes.push_back(sentence_beat(
            (sum & rrsf_pkg::NIBBLE_LO) + rrsf_pkg::ASCII_ZERO, 1'b0));
        pending_bytes.push_back(sentence_beat(rrsf_pkg::ASCII_CR, 1'b0));
        pending_bytes.push_back(sentence_beat(rrsf_pkg::ASCII_LF, 1'b1));
    endtask

    // Present one request and hold it until the block takes it. Start is left
    // high so that a following request can go straight in.
    task automatic send_request(input rrsf_pkg::t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        frame_sentence(r);
        requests_sent++;
        if (r.req_type == rrsf_pkg::REQ_IDENT) begin
            ident_sent++;
        end else begin
            freq_sent++;
        end
    endtask

    // Random pause on the request side, with junk on the request bus meanwhile.
    task automatic idle_sender(input int pct);
        logic [63:0] junk;
        if (pct > 0 && $urandom_range(99) < pct) begin
            junk = {$urandom, $urandom};
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= junk[$bits(rrsf_pkg::t_req)-1:0];
            while ($urandom_range(99) < pct) begin
                @(negedge i_clk);
            end
        end
    endtask

    // Unused frequency fields are filled so that the block must ignore them.
    function automatic rrsf_pkg::t_req make_ident(input logic [3:0] idx,
                                                  input logic [7:0] c0,
                                                  input logic [7:0] c1,
                                                  input logic [7:0] c2,
                                                  input logic [7:0] c3);
        rrsf_pkg::t_req r;
        r.req_type     = rrsf_pkg::REQ_IDENT;
        r.list_index   = idx;
        r.ident_char_0 = c0;
        r.ident_char_1 = c1;
        r.ident_char_2 = c2;
        r.ident_char_3 = c3;
        r.freq_kind    = 8'($urandom_range(255, 1));
        r.mhz_code     = 8'($urandom_range(255, 1));
        r.khz_code     = 8'($urandom_range(255, 1));
        return r;
    endfunction

    // Unused ident fields are filled so that the block must ignore them.
    function automatic rrsf_pkg::t_req make_freq(input logic [3:0] idx,
                                                 input logic [7:0] kind,
                                                 input logic [7:0] mhz,
                                                 input logic [7:0] khz);
        rrsf_pkg::t_req r;
        r.req_type     = rrsf_pkg::REQ_FREQ;
        r.list_index   = idx;
        r.ident_char_0 = 8'($urandom_range(255, 1));
        r.ident_char_1 = 8'($urandom_range(255, 1));
        r.ident_char_2 = 8'($urandom_range(255, 1));
        r.ident_char_3 = 8'($urandom_range(255, 1));
        r.freq_kind    = kind;
        r.mhz_code     = mhz;
        r.khz_code     = khz;
        return r;
    endfunction

    // A byte that is zero about one time in five, so fields get cut short often.
    function automatic logic [7:0] random_field();
        return ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    function automatic rrsf_pkg::t_req random_request();
        rrsf_pkg::t_req r;
        r.req_type     = 1'($urandom_range(1));
        r.list_index   = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10))
                                                  : 4'($urandom_range(9));
        r.ident_char_0 = random_field();
        r.ident_char_1 = random_field();
        r.ident_char_2 = random_field();
        r.ident_char_3 = random_field();
        r.freq_kind    = random_field();
        r.mhz_code     = random_field();
        r.khz_code     = random_field();
        return r;
    endfunction

    // Ident sentences: empty, full, early zero, extreme bytes and list digits.
    task automatic check_ident_sentences();
        send_request(make_ident(4'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_ident(4'd9, "A", "B", "C", "D"));
        send_request(make_ident(4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_ident(4'd10, "X", 8'h00, "Y", "Z"));
        send_request(make_ident(4'd5, 8'h00, "Q", "R", "S"));
        send_request(make_ident(4'd3, "K", "7", "Z", 8'h00));
        send_request(make_ident(4'd1, 8'h01, 8'h80, 8'h7F, 8'hFE));
        send_request(make_ident(4'd12, "a", 8'h00, 8'h00, 8'h00));
    endtask

    // Frequency list sentences: each byte omitted in turn, none, all, extremes.
    task automatic check_freq_sentences();
        send_request(make_freq(4'd0, 8'h00, 8'h00, 8'h00));
        send_request(make_freq(4'd9, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_freq(4'd15, 8'h01, 8'h80, 8'h7F));
        send_request(make_freq(4'd2, 8'h00, "5", "5"));
        send_request(make_freq(4'd7, "K", 8'h00, "9"));
        send_request(make_freq(4'd8, "K", "1", 8'h00));
        send_request(make_freq(4'd11, 8'h55, 8'hAA, 8'h00));
        send_request(make_freq(4'd4, 8'h00, 8'h00, 8'hC3));
    endtask

    // Random requests with the given share of idle cycles before each one.
    task automatic check_random_traffic(input int idle_pct, input int count);
        for (int n = 0; n < count; n++) begin
            idle_sender(idle_pct);
            send_request(random_request());
        end
    endtask

    // Let the last sentence run out, then watch for stray beats.
    task automatic drain_sentences();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Compare every strobed beat with the oldest byte still owed.
    always @(posedge i_clk) begin : check_beats
        rrsf_pkg::t_res want;
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            if (pending_bytes.size() == 0) begin
                report_fault($sformatf("beat with nothing owed: byte %h last %b",
                                       o_res.out_byte, o_res.last_byte));
            end else begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (o_strobe !== 1'b1 || o_res.out_byte !== want.out_byte ||
                        o_res.last_byte !== want.last_byte) begin
                    report_fault($sformatf(
                        "beat mismatch: expected byte %h last %b, got %h last %b (strobe %b)",
                        want.out_byte, want.last_byte,
                        o_res.out_byte, o_res.last_byte, o_strobe));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d bytes still owed.",
                     cycle_count, pending_bytes.size());
            $display("radio_remote_sentence_framer verification failed");
            $finish;
        end
    end

    initial begin
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_ident_sentences();
        check_freq_sentences();
        check_random_traffic(0, 74);
        check_random_traffic(87, 73);
        check_random_traffic(38, 73);
        drain_sentences();

        if (pending_bytes.size() != 0) begin
            report_fault($sformatf("%0d sentence bytes never arrived",
                                   pending_bytes.size()));
        end
        $display("Sent %0d requests (%0d ident, %0d frequency list), %0d bytes, %0d faults.",
                 requests_sent, ident_sent, freq_sent, bytes_checked, faults);
        $display("Covered field extremes, cut-short idents, omitted frequency bytes");
        $display("and three request idle mixes.");
        if (faults == 0) begin
            $display("radio_remote_sentence_framer verification clean");
        end else begin
            $display("radio_remote_sentence_framer verification failed");
        end
        $finish;
    end

endmodule
